>>> sv/efr_pkg.sv
// efr_pkg: shared types, codes and the byte-wide crc16 update for the escaped frame receiver
// no dependencies; imported by efr_skid and escaped_frame_receiver_crc16_unit
`default_nettype none

package efr_pkg;

	localparam int BUFFER_SIZE_DEF  = 256;
	localparam int HEADER_BYTES_DEF = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// expected length holds the raw size field first, then header + size + tail
	localparam int EXP_W = 17;
	localparam int SUM_W = 18;

	localparam int TAIL_BYTES = 2;
	localparam int SIZE_LO_IDX = 2;
	localparam int SIZE_HI_IDX = 3;

	localparam logic [15:0] CRC_POLY       = 16'h1021;
	localparam logic [7:0]  START_BYTE_RST = 8'd126;
	localparam logic [7:0]  ESC_BYTE_RST   = 8'd92;
	localparam logic [7:0]  FLIP_MASK_RST  = 8'd64;
	localparam logic [15:0] CRC_SEED_RST   = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BYTE  = 2'd0,
		REG_ESCAPE_BYTE = 2'd1,
		REG_FLIP_MASK   = 2'd2,
		REG_CRC_SEED    = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_BUSY     = 4'd0,
		ST_NOSTART  = 4'd1,
		ST_START    = 4'd2,
		ST_ESCAPE   = 4'd3,
		ST_STORED   = 4'd4,
		ST_GOOD     = 4'd5,
		ST_BADESC   = 4'd6,
		ST_BADLEN   = 4'd7,
		ST_CRCERR   = 4'd8,
		ST_RELEASED = 4'd9
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [8:0]  frame_length;
	} result_t;

	// crc16-ccitt, msb first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> sv/escaped_frame_receiver_crc16_unit.sv
// escaped_frame_receiver_crc16_unit: byte-stuffed frame parser with crc16 tail check
// depends on efr_pkg and efr_skid
//
//   channel  handshake                 payload
//   input    in_valid / in_stall       cmd, rx_byte
//   output   out_valid / out_stall     status, data_byte, byte_index, frame_length
//   config   cfg_write                 cfg_index, cfg_data
//
// one item per cycle while in_stall is low; each accepted item gives one result, computed
// from the parser state registers and the byte-wide crc update, and registered in efr_skid.
// reset clears the parser and loads the register defaults; no clearing pass.
// a stalled output fills the skid stage; in_stall rises only when both entries are full.
`default_nettype none

module escaped_frame_receiver_crc16_unit
	import efr_pkg::*;
#(
	parameter int BUFFER_SIZE  = BUFFER_SIZE_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  cmd,
	input  wire logic [7:0]            rx_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [3:0]                 status,
	output logic [7:0]                 data_byte,
	output logic [7:0]                 byte_index,
	output logic [8:0]                 frame_length
);

	localparam int FILL_MAX = (BUFFER_SIZE > HEADER_BYTES) ? BUFFER_SIZE : HEADER_BYTES;
	localparam int FW       = $clog2(FILL_MAX + 1);

	logic [7:0]       start_byte_q;
	logic [7:0]       escape_byte_q;
	logic [7:0]       flip_mask_q;
	logic [15:0]      crc_seed_q;

	logic             in_frame_q, esc_q, busy_q;
	logic [FW-1:0]    fill_q;
	logic [EXP_W-1:0] exp_q;
	logic [15:0]      crc_q, rcrc_q;

	logic             in_frame_n, esc_n, busy_n;
	logic [FW-1:0]    fill_n;
	logic [EXP_W-1:0] exp_n;
	logic [15:0]      crc_n, rcrc_n;

	logic             acc;
	result_t          res;
	result_t          out_res;
	logic [7:0]       v;
	logic [FW-1:0]    idx, nxt;
	logic [SUM_W-1:0] idx_plus;
	logic [SUM_W-1:0] hdr_sum;
	logic             parser_clr;

	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= START_BYTE_RST;
			escape_byte_q <= ESC_BYTE_RST;
			flip_mask_q   <= FLIP_MASK_RST;
			crc_seed_q    <= CRC_SEED_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START_BYTE:  start_byte_q  <= cfg_data[7:0];
				REG_ESCAPE_BYTE: escape_byte_q <= cfg_data[7:0];
				REG_FLIP_MASK:   flip_mask_q   <= cfg_data[7:0];
				REG_CRC_SEED:    crc_seed_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		in_frame_n = in_frame_q;
		esc_n      = esc_q;
		busy_n     = busy_q;
		fill_n     = fill_q;
		exp_n      = exp_q;
		crc_n      = crc_q;
		rcrc_n     = rcrc_q;
		parser_clr = 1'b0;
		res        = '{status: ST_STORED, data_byte: 8'd0, byte_index: 8'd0, frame_length: 9'd0};
		v          = esc_q ? (rx_byte ^ flip_mask_q) : rx_byte;
		idx        = fill_q;
		nxt        = fill_q + FW'(1);
		idx_plus   = SUM_W'(fill_q) + SUM_W'(TAIL_BYTES);
		hdr_sum    = '0;

		if (cmd) begin
			busy_n     = 1'b0;
			fill_n     = '0;
			esc_n      = 1'b0;
			crc_n      = crc_seed_q;
			res.status = ST_RELEASED;
		end else if (busy_q) begin
			res.status = ST_BUSY;
		end else if (esc_q && (rx_byte == start_byte_q || rx_byte == escape_byte_q)) begin
			parser_clr = 1'b1;
			res.status = ST_BADESC;
		end else if (rx_byte == start_byte_q) begin
			parser_clr = 1'b1;
			in_frame_n = 1'b1;
			res.status = ST_START;
		end else if (!in_frame_q) begin
			res.status = ST_NOSTART;
		end else if (rx_byte == escape_byte_q) begin
			esc_n      = 1'b1;
			res.status = ST_ESCAPE;
		end else begin
			esc_n          = 1'b0;
			fill_n         = nxt;
			res.data_byte  = v;
			res.byte_index = 8'(idx);
			if (idx < FW'(HEADER_BYTES)) begin
				crc_n = crc16_byte(crc_q, v);
				if (idx == FW'(SIZE_LO_IDX)) begin
					exp_n = EXP_W'(v);
				end else if (idx == FW'(SIZE_HI_IDX)) begin
					exp_n = exp_q | (EXP_W'(v) << 8);
				end
				if (nxt == FW'(HEADER_BYTES)) begin
					hdr_sum = SUM_W'(exp_n) + SUM_W'(HEADER_BYTES + TAIL_BYTES);
					if (hdr_sum > SUM_W'(BUFFER_SIZE)) begin
						parser_clr = 1'b1;
						res.status = ST_BADLEN;
					end else begin
						exp_n = hdr_sum[EXP_W-1:0];
					end
				end
			end else if (idx_plus < SUM_W'(exp_q)) begin
				crc_n = crc16_byte(crc_q, v);
			end else if (idx_plus == SUM_W'(exp_q)) begin
				rcrc_n = {8'h00, v};
			end else begin
				rcrc_n = rcrc_q | {v, 8'h00};
			end
			if (!parser_clr && nxt >= FW'(HEADER_BYTES)
					&& SUM_W'(nxt) >= SUM_W'(exp_n)) begin
				if (crc_n != rcrc_n) begin
					parser_clr = 1'b1;
					res.status = ST_CRCERR;
				end else begin
					busy_n           = 1'b1;
					res.status       = ST_GOOD;
					res.frame_length = 9'(nxt);
				end
			end
		end

		if (parser_clr) begin
			esc_n  = 1'b0;
			fill_n = '0;
			exp_n  = '0;
			crc_n  = crc_seed_q;
			rcrc_n = '0;
			if (res.status != ST_START) begin
				in_frame_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			busy_q     <= 1'b0;
			fill_q     <= '0;
			exp_q      <= '0;
			crc_q      <= CRC_SEED_RST;
			rcrc_q     <= '0;
		end else if (acc) begin
			in_frame_q <= in_frame_n;
			esc_q      <= esc_n;
			busy_q     <= busy_n;
			fill_q     <= fill_n;
			exp_q      <= exp_n;
			crc_q      <= crc_n;
			rcrc_q     <= rcrc_n;
		end
	end

	efr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc),
		.in_data   (res),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_data  (out_res),
		.out_stall (out_stall)
	);

	assign status       = out_res.status;
	assign data_byte    = out_res.data_byte;
	assign byte_index   = out_res.byte_index;
	assign frame_length = out_res.frame_length;

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_idle_parser_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (fill_q == '0 && !esc_q))
		else $error("parser state left over outside a frame");

	a_busy_full_header: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (fill_q >= FW'(HEADER_BYTES)))
		else $error("busy without a complete header");

	a_good_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && res.status == ST_GOOD) |=> busy_q)
		else $error("good frame did not set busy");

endmodule

`default_nettype wire

>>> sv/efr_skid.sv
// efr_skid: two-entry result buffer, output register plus skid stage
// depends on efr_pkg for result_t
`default_nettype none

module efr_skid
	import efr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire result_t in_data,
	output logic         in_stall,
	output logic         out_valid,
	output result_t      out_data,
	input  wire logic    out_stall
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (main_valid_q && out_stall) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (!out_stall) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_stall) begin
				main_q <= skid_q;
			end
		end else if (in_valid) begin
			if (main_valid_q && out_stall) begin
				skid_q <= in_data;
			end else begin
				main_q <= in_data;
			end
		end
	end

	assign in_stall  = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench for escaped_frame_receiver_crc16_unit: queued serial items with random gaps and
// stalls, results checked in order against an in-bench frame parser prediction
// depends on efr_pkg and the escaped_frame_receiver_crc16_unit rtl
`timescale 1ns / 1ps

module testbench;
	import efr_pkg::*;

	localparam int unsigned HDR = HEADER_BYTES_DEF;
	localparam int unsigned BUF = BUFFER_SIZE_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx;
	} serial_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  cmd = 1'b0;
	logic [7:0]            rx_byte = 8'h00;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [3:0]            status;
	logic [7:0]            data_byte;
	logic [7:0]            byte_index;
	logic [8:0]            frame_length;

	serial_item_t pending_items[$];
	result_t      expected_results[$];
	int unsigned  queued_count = 0;
	int unsigned  items_taken = 0;
	int unsigned  errors = 0;
	int unsigned  cycle_count = 0;
	int unsigned  send_gap = 0;
	int unsigned  recv_gap = 0;
	int unsigned  hold_cycles = 0;
	int unsigned  holds_done = 0;
	bit           calm = 1'b0;

	// register copies
	logic [7:0]  cfg_start = START_BYTE_RST;
	logic [7:0]  cfg_escape = ESC_BYTE_RST;
	logic [7:0]  cfg_flip = FLIP_MASK_RST;
	logic [15:0] cfg_seed = CRC_SEED_RST;

	// parser state copies
	bit          p_in_frame = 1'b0;
	bit          p_esc_wait = 1'b0;
	bit          p_busy = 1'b0;
	int unsigned p_fill = 0;
	int unsigned p_length = 0;
	logic [15:0] p_crc = CRC_SEED_RST;
	logic [15:0] p_tail_crc = 16'h0000;

	escaped_frame_receiver_crc16_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.frame_length (frame_length)
	);

	always #4 clk = ~clk;

	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] acc;
		logic        fb;
		acc = c;
		for (int i = 7; i >= 0; i--) begin
			fb = acc[15] ^ d[i];
			acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return acc;
	endfunction

	function automatic int unsigned gap_draw();
		if (calm) begin
			return 0;
		end
		if ($urandom_range(0, 2) == 0) begin
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	task automatic parser_clear();
		p_in_frame = 1'b0;
		p_esc_wait = 1'b0;
		p_fill = 0;
		p_length = 0;
		p_crc = cfg_seed;
		p_tail_crc = 16'h0000;
	endtask

	task automatic frame_predict(input logic c, input logic [7:0] b, output result_t r);
		logic [7:0]  v;
		int unsigned idx;
		bit          bad;
		v = b;
		bad = 1'b0;
		r = '0;
		if (c) begin
			p_busy = 1'b0;
			p_fill = 0;
			p_esc_wait = 1'b0;
			p_crc = cfg_seed;
			r.status = ST_RELEASED;
		end else if (p_busy) begin
			r.status = ST_BUSY;
		end else if (p_esc_wait && (v == cfg_start || v == cfg_escape)) begin
			parser_clear();
			r.status = ST_BADESC;
		end else if (v == cfg_start) begin
			parser_clear();
			p_in_frame = 1'b1;
			r.status = ST_START;
		end else if (!p_in_frame) begin
			r.status = ST_NOSTART;
		end else if (v == cfg_escape) begin
			p_esc_wait = 1'b1;
			r.status = ST_ESCAPE;
		end else begin
			if (p_esc_wait) begin
				v = v ^ cfg_flip;
				p_esc_wait = 1'b0;
			end
			idx = p_fill;
			p_fill = idx + 1;
			r.status = ST_STORED;
			r.data_byte = v;
			r.byte_index = idx[7:0];
			if (idx < HDR) begin
				p_crc = crc_next(p_crc, v);
				if (idx == SIZE_LO_IDX) begin
					p_length = 32'(v);
				end else if (idx == SIZE_HI_IDX) begin
					p_length = p_length | (32'(v) << 8);
				end
				if (p_fill == HDR) begin
					if (p_length + HDR + TAIL_BYTES > BUF) begin
						parser_clear();
						r.status = ST_BADLEN;
						bad = 1'b1;
					end else begin
						p_length = p_length + HDR + TAIL_BYTES;
					end
				end
			end else begin
				if (idx + 2 < p_length) begin
					p_crc = crc_next(p_crc, v);
				end else if (idx + 2 == p_length) begin
					p_tail_crc = {8'h00, v};
				end else begin
					p_tail_crc = p_tail_crc | {v, 8'h00};
				end
			end
			if (!bad && p_fill >= HDR && p_fill >= p_length) begin
				if (p_crc != p_tail_crc) begin
					parser_clear();
					r.status = ST_CRCERR;
				end else begin
					p_busy = 1'b1;
					r.status = ST_GOOD;
					r.frame_length = p_fill[8:0];
				end
			end
		end
	endtask

	task automatic item_push(input logic c, input logic [7:0] b);
		serial_item_t it;
		it.cmd = c;
		it.rx = b;
		pending_items.push_back(it);
		queued_count++;
	endtask

	// stuffed byte: special values go out as escape plus flipped value
	task automatic byte_push(input logic [7:0] b);
		if (b == cfg_start || b == cfg_escape) begin
			item_push(1'b0, cfg_escape);
			item_push(1'b0, b ^ cfg_flip);
		end else begin
			item_push(1'b0, b);
		end
	endtask

	task automatic frame_push(input logic [7:0] h0, input int unsigned size, input bit with_start,
			input bit bad_crc);
		logic [7:0]  raw[$];
		logic [15:0] crc;
		bit          fits;
		raw = {};
		fits = (size + HDR + TAIL_BYTES <= BUF);
		raw.push_back(h0);
		raw.push_back(8'($urandom));
		raw.push_back(size[7:0]);
		raw.push_back(size[15:8]);
		if (fits) begin
			for (int unsigned i = 0; i < size; i++) begin
				raw.push_back(8'($urandom));
			end
			crc = cfg_seed;
			for (int unsigned i = 0; i < raw.size(); i++) begin
				crc = crc_next(crc, raw[i]);
			end
			if (bad_crc) begin
				crc = crc ^ (16'h0001 << $urandom_range(0, 15));
			end
			raw.push_back(crc[7:0]);
			raw.push_back(crc[15:8]);
		end
		if (with_start) begin
			item_push(1'b0, cfg_start);
		end
		for (int unsigned i = 0; i < raw.size(); i++) begin
			byte_push(raw[i]);
		end
	endtask

	task automatic random_traffic(input int unsigned n, input bit with_big);
		int unsigned goal;
		int unsigned pick;
		int unsigned cnt;
		goal = queued_count + n;
		if (with_big) begin
			frame_push(8'($urandom), BUF - HDR - TAIL_BYTES, 1'b1, 1'b0);
			item_push(1'b1, 8'($urandom));
		end
		while (queued_count < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				frame_push(8'($urandom), $urandom_range(0, 24), $urandom_range(0, 99) < 85,
					$urandom_range(0, 9) == 0);
				cnt = $urandom_range(0, 2);
				for (int unsigned i = 0; i < cnt; i++) begin
					item_push(1'b0, 8'($urandom));
				end
				if ($urandom_range(0, 9) != 0) begin
					item_push(1'b1, 8'($urandom));
				end
			end else if (pick < 80) begin
				frame_push(8'($urandom),
					$urandom_range(0, 1) ? $urandom_range(251, 260) : $urandom_range(251, 65535),
					1'b1, 1'b0);
			end else if (pick < 88) begin
				// truncated frame
				item_push(1'b0, cfg_start);
				cnt = $urandom_range(1, 8);
				for (int unsigned i = 0; i < cnt; i++) begin
					item_push(1'b0, 8'($urandom));
				end
			end else if (pick < 93) begin
				item_push(1'b0, cfg_start);
				item_push(1'b0, 8'($urandom));
				item_push(1'b0, cfg_escape);
				item_push(1'b0, $urandom_range(0, 1) ? cfg_start : cfg_escape);
			end else begin
				cnt = $urandom_range(1, 6);
				for (int unsigned i = 0; i < cnt; i++) begin
					item_push($urandom_range(0, 19) == 0, 8'($urandom));
				end
			end
		end
	endtask

	task automatic reg_write(input cfg_reg_t r, input logic [15:0] d);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (r)
			REG_START_BYTE: begin
				cfg_start = d[7:0];
			end
			REG_ESCAPE_BYTE: begin
				cfg_escape = d[7:0];
			end
			REG_FLIP_MASK: begin
				cfg_flip = d[7:0];
			end
			default: begin
				cfg_seed = d;
			end
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin : item_drive
		serial_item_t it;
		result_t      predicted;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				frame_predict(cmd, rx_byte, predicted);
				expected_results.push_back(predicted);
				items_taken <= items_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_items.size() != 0) begin
					it = pending_items.pop_front();
					in_valid <= 1'b1;
					cmd <= it.cmd;
					rx_byte <= it.rx;
					send_gap <= gap_draw();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-offs so the skid stage fills and the input stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_cycles != 0) begin
				hold_cycles <= hold_cycles - 1;
			end else if (holds_done < 2 && items_taken >= 60 + holds_done * 340) begin
				hold_cycles <= 150;
				holds_done <= holds_done + 1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t     want;
		int unsigned next_gap;
		if (arst_n) begin
			next_gap = recv_gap;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no item outstanding, status %0d", status);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status expected %0d got %0d", want.status, status);
						errors++;
					end
					if (data_byte !== want.data_byte) begin
						$error("data_byte expected %0d got %0d", want.data_byte, data_byte);
						errors++;
					end
					if (byte_index !== want.byte_index) begin
						$error("byte_index expected %0d got %0d", want.byte_index, byte_index);
						errors++;
					end
					if (frame_length !== want.frame_length) begin
						$error("frame_length expected %0d got %0d", want.frame_length,
							frame_length);
						errors++;
					end
				end
				next_gap = gap_draw();
			end else if (next_gap != 0) begin
				next_gap = next_gap - 1;
			end
			recv_gap <= next_gap;
			out_stall <= (next_gap != 0) || (hold_cycles != 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes outside a frame and a release while idle
		item_push(1'b0, 8'h00);
		item_push(1'b0, 8'hFF);
		item_push(1'b1, 8'hA5);
		// escape followed by escape, then by start
		item_push(1'b0, START_BYTE_RST);
		item_push(1'b0, ESC_BYTE_RST);
		item_push(1'b0, ESC_BYTE_RST);
		item_push(1'b0, START_BYTE_RST);
		item_push(1'b0, ESC_BYTE_RST);
		item_push(1'b0, START_BYTE_RST);
		// good empty frame with an escaped header byte, a byte while busy, release
		frame_push(START_BYTE_RST, 0, 1'b1, 1'b0);
		item_push(1'b0, START_BYTE_RST);
		item_push(1'b1, 8'h00);
		// largest size field
		frame_push(8'h00, 65535, 1'b1, 1'b0);
		drain();

		random_traffic(60, 1'b0);
		drain();

		reg_write(REG_START_BYTE, 16'hAB00);
		reg_write(REG_ESCAPE_BYTE, 16'h00FF);
		reg_write(REG_FLIP_MASK, 16'h0020);
		reg_write(REG_CRC_SEED, 16'h0000);
		random_traffic(60, 1'b1);
		drain();

		reg_write(REG_START_BYTE, 16'h00FF);
		reg_write(REG_ESCAPE_BYTE, 16'hFF00);
		reg_write(REG_FLIP_MASK, 16'h0080);
		reg_write(REG_CRC_SEED, 16'hFFFF);
		random_traffic(60, 1'b0);
		drain();

		// start and escape share one value, no flip
		calm = 1'b1;
		reg_write(REG_START_BYTE, 16'h0055);
		reg_write(REG_ESCAPE_BYTE, 16'h0055);
		reg_write(REG_FLIP_MASK, 16'h0000);
		reg_write(REG_CRC_SEED, 16'h1D0F);
		random_traffic(40, 1'b0);
		drain();
		calm = 1'b0;

		reg_write(REG_START_BYTE, 16'($urandom));
		reg_write(REG_ESCAPE_BYTE, 16'($urandom));
		reg_write(REG_FLIP_MASK, 16'($urandom));
		reg_write(REG_CRC_SEED, 16'($urandom));
		random_traffic(60, 1'b0);
		drain();

		if (errors == 0 && expected_results.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/efr_pkg.sv
sv/efr_skid.sv
sv/escaped_frame_receiver_crc16_unit.sv
tb/testbench.sv
